@@ src/dialu_pkg.sv @@
// ----------------------------------------------------------------------------
// dialu_pkg
// Types and codes shared by the 32-bit integer ALU with flags: item structs,
// command and status codes, flag bit positions, iteration counts and quotient limits.
// ----------------------------------------------------------------------------
package dialu_pkg;

  // Command codes
  localparam logic [2:0] CMD_LOAD = 3'd0;
  localparam logic [2:0] CMD_ADD  = 3'd1;
  localparam logic [2:0] CMD_SUB  = 3'd2;
  localparam logic [2:0] CMD_MUL  = 3'd3;
  localparam logic [2:0] CMD_DIV  = 3'd4;

  // Status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_DIV_ZERO = 2'd1;
  localparam logic [1:0] STAT_DIV_OVF  = 2'd2;

  // Flag bit positions in the flag word
  localparam int FLAG_Z = 15;
  localparam int FLAG_M = 14;
  localparam int FLAG_V = 13;
  localparam int FLAG_C = 12;

  // Last value of the iteration counter for each serial operation
  localparam logic [4:0] ADD_LAST = 5'd31;
  localparam logic [4:0] MUL_LAST = 5'd15;
  localparam logic [4:0] DIV_LAST = 5'd31;

  // Quotient magnitude limits for a 16-bit signed result
  localparam logic [31:0] QMAG_POS_MAX = 32'd32767;
  localparam logic [31:0] QMAG_NEG_MAX = 32'd32768;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] operand_high;
    logic [15:0] operand_low;
    logic [15:0] flags_in;
  } cmd_item_t;

  typedef struct packed {
    logic [15:0] high_word;
    logic [15:0] low_word;
    logic [15:0] flag_word;
    logic [1:0]  status;
  } res_item_t;

endpackage

@@ src/dword_integer_alu_with_flags.sv @@
// ----------------------------------------------------------------------------
// dword_integer_alu_with_flags
// Bit-serial integer ALU on a 32-bit accumulator with a 16-bit flag word.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the cmd channel (cmd_valid / cmd_stall, payload cmd)
//   and each one gives exactly one result item on the res channel
//   (res_valid / res_stall, payload res) holding the accumulator words, the
//   flag word and a status code.
//   One command is worked on at a time; cmd_stall is high from acceptance
//   until the result has been moved into the output register.
//   Load, unused codes and divide by zero go straight to the result push.
//   Multiply works one multiplier bit per cycle through a 17-bit
//   shift-add; add/subtract one sum bit per cycle through a 1-bit full
//   adder; divide one quotient bit per cycle of a restoring divider,
//   followed by a sign-fix step. The next command can be taken in the
//   cycle after the result register is loaded.
//   A finished result waits in its state while res_stall holds the output
//   register full; the output register is held stable until taken.
//   Reset (rst, synchronous) clears the accumulator, the flags and all
//   handshake state.
// ----------------------------------------------------------------------------
module dword_integer_alu_with_flags
  import dialu_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_stall,
  input  cmd_item_t cmd,
  output logic      res_valid,
  input  logic      res_stall,
  output res_item_t res
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ADD    = 3'd1;
  localparam logic [2:0] ST_MUL    = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_DIVFIN = 3'd4;
  localparam logic [2:0] ST_PUSH   = 3'd5;

  logic [2:0]  state;
  logic [4:0]  cnt;
  logic [15:0] acc_high;
  logic [15:0] acc_low;
  logic [15:0] flag_reg;
  logic [1:0]  status_r;

  // Work registers
  logic [31:0] wa;        // sum / multiplier+product low / dividend+quotient
  logic [31:0] wb;        // add operand
  logic [16:0] mhi;       // product high part
  logic [15:0] rem;       // partial remainder
  logic [15:0] dmag;      // divisor magnitude
  logic        sub_r;
  logic        seen;      // a one has passed in the operand (serial negate)
  logic        carry;
  logic        nz;
  logic        a_neg;
  logic        d_neg;

  logic accept;
  logic push_go;

  assign cmd_stall = (state != ST_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign push_go   = (state == ST_PUSH) && (!res_valid || !res_stall);

  // Operand magnitudes for divide
  logic [31:0] acc32;
  logic [31:0] amag;
  logic [15:0] omag;

  assign acc32 = {acc_high, acc_low};
  assign amag  = acc32[31] ? (~acc32 + 32'd1) : acc32;
  assign omag  = cmd.operand_low[15] ? (~cmd.operand_low + 16'd1) : cmd.operand_low;

  // Serial add step: one sum bit per cycle
  logic add_a, add_b, add_s, add_c, add_ovf;

  always_comb begin
    add_a   = wa[0];
    add_b   = sub_r ? (wb[0] ^ seen) : wb[0];
    add_s   = add_a ^ add_b ^ carry;
    add_c   = (add_a & add_b) | (add_a & carry) | (add_b & carry);
    add_ovf = (add_a == add_b) && (add_s != add_a);
  end

  // Multiply step: signed shift-add, last partial product subtracted
  logic [17:0] mcand;
  logic [17:0] mpp;
  logic [17:0] msum;
  logic [31:0] mprod;

  always_comb begin
    mcand = {{2{acc_low[15]}}, acc_low};
    if (!wa[0]) begin
      mpp = 18'd0;
    end else if (cnt == MUL_LAST) begin
      mpp = ~mcand + 18'd1;
    end else begin
      mpp = mcand;
    end
    msum  = {mhi[16], mhi} + mpp;
    mprod = {msum[16:1], msum[0], wa[15:1]};
  end

  // Divide step: restoring, one quotient bit per cycle
  logic [16:0] dtrial;
  logic [17:0] ddiff;
  logic        dqbit;

  always_comb begin
    dtrial = {rem, wa[31]};
    ddiff  = {1'b0, dtrial} - {2'b00, dmag};
    dqbit  = !ddiff[17];
  end

  // Divide sign fix and range check
  logic        q_neg;
  logic        q_ovf;
  logic [15:0] q_val;
  logic [15:0] r_val;

  always_comb begin
    q_neg = a_neg ^ d_neg;
    q_ovf = q_neg ? (wa > QMAG_NEG_MAX) : (wa > QMAG_POS_MAX);
    q_val = q_neg ? (~wa[15:0] + 16'd1) : wa[15:0];
    r_val = a_neg ? (~rem + 16'd1) : rem;
  end

  // Control and accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      acc_high <= 16'd0;
      acc_low  <= 16'd0;
      flag_reg <= 16'd0;
      cnt      <= 5'd0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            cnt      <= 5'd0;
            status_r <= STAT_OK;
            case (cmd.command)
              CMD_LOAD: begin
                acc_high <= cmd.operand_high;
                acc_low  <= cmd.operand_low;
                flag_reg <= cmd.flags_in;
                state    <= ST_PUSH;
              end
              CMD_ADD, CMD_SUB: begin
                wa    <= acc32;
                wb    <= {cmd.operand_high, cmd.operand_low};
                sub_r <= (cmd.command == CMD_SUB);
                seen  <= 1'b0;
                carry <= 1'b0;
                nz    <= 1'b0;
                state <= ST_ADD;
              end
              CMD_MUL: begin
                wa[15:0] <= cmd.operand_low;
                mhi      <= 17'd0;
                state    <= ST_MUL;
              end
              CMD_DIV: begin
                if (cmd.operand_low == 16'd0) begin
                  status_r <= STAT_DIV_ZERO;
                  state    <= ST_PUSH;
                end else begin
                  wa    <= amag;
                  dmag  <= omag;
                  rem   <= 16'd0;
                  a_neg <= acc32[31];
                  d_neg <= cmd.operand_low[15];
                  state <= ST_DIV;
                end
              end
              default: begin
                state <= ST_PUSH;
              end
            endcase
          end
        end
        ST_ADD: begin
          wa    <= {add_s, wa[31:1]};
          wb    <= {1'b0, wb[31:1]};
          seen  <= seen | wb[0];
          carry <= add_c;
          nz    <= nz | add_s;
          cnt   <= cnt + 5'd1;
          if (cnt == ADD_LAST) begin
            acc_high         <= {add_s, wa[31:17]};
            acc_low          <= wa[16:1];
            flag_reg[FLAG_V] <= flag_reg[FLAG_V] | add_ovf;
            flag_reg[FLAG_M] <= add_s ^ add_ovf;
            flag_reg[FLAG_C] <= add_c;
            flag_reg[FLAG_Z] <= !(nz | add_s);
            state            <= ST_PUSH;
          end
        end
        ST_MUL: begin
          mhi      <= msum[17:1];
          wa[15:0] <= {msum[0], wa[15:1]};
          cnt      <= cnt + 5'd1;
          if (cnt == MUL_LAST) begin
            acc_high         <= mprod[31:16];
            acc_low          <= mprod[15:0];
            flag_reg[FLAG_M] <= mprod[31];
            flag_reg[FLAG_Z] <= (mprod == 32'd0);
            state            <= ST_PUSH;
          end
        end
        ST_DIV: begin
          rem <= dqbit ? ddiff[15:0] : dtrial[15:0];
          wa  <= {wa[30:0], dqbit};
          cnt <= cnt + 5'd1;
          if (cnt == DIV_LAST) begin
            state <= ST_DIVFIN;
          end
        end
        ST_DIVFIN: begin
          if (q_ovf) begin
            status_r <= STAT_DIV_OVF;
          end else begin
            acc_low          <= q_val;
            acc_high         <= r_val;
            flag_reg[FLAG_M] <= q_neg && (wa != 32'd0);
            flag_reg[FLAG_Z] <= (wa == 32'd0);
          end
          state <= ST_PUSH;
        end
        ST_PUSH: begin
          if (push_go) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (push_go) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_go) begin
      res.high_word <= acc_high;
      res.low_word  <= acc_low;
      res.flag_word <= flag_reg;
      res.status    <= status_r;
    end
  end

  // Checks
  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (rst)
    accept |=> cmd_stall
  ) else $error("command accepted but block not busy next cycle");

  a_add_ends: assert property (
    @(posedge clk) disable iff (rst)
    (state == ST_ADD && cnt == ADD_LAST) |=> (state == ST_PUSH)
  ) else $error("add did not finish after 32 bits");

  a_low_flags_kept: assert property (
    @(posedge clk) disable iff (rst)
    (state != ST_IDLE) |=> (flag_reg[11:0] == $past(flag_reg[11:0]))
  ) else $error("unused flag bits changed outside a load");

endmodule
